@@ src/wsfr_pkg.sv @@
// wsfr_pkg: shared types and constants of the websocket frame receiver
// used by the channel interfaces and by the receiver top level

package wsfr_pkg;

  // field widths of the request and result channels
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [KindW-1:0] kind_t;

  // result kinds
  localparam kind_t KIND_DATA  = 3'd0;
  localparam kind_t KIND_CLOSE = 3'd1;
  localparam kind_t KIND_BADOP = 3'd2;
  localparam kind_t KIND_TOOBIG = 3'd3;
  localparam kind_t KIND_EMPTY = 3'd4;

  // parser phases
  typedef logic [2:0] phase_t;
  localparam phase_t PH_FIRST   = 3'd0;
  localparam phase_t PH_SECOND  = 3'd1;
  localparam phase_t PH_EXT     = 3'd2;
  localparam phase_t PH_PAYLOAD = 3'd3;
  localparam phase_t PH_STOPPED = 3'd4;

  // length forms selected by the second header byte
  typedef logic [1:0] len_mode_t;
  localparam len_mode_t LEN_SHORT = 2'd0;
  localparam len_mode_t LEN_16    = 2'd1;
  localparam len_mode_t LEN_64    = 2'd2;

  // header constants
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN7_16   = 7'd126;
  localparam logic [6:0] LEN7_64   = 7'd127;
  localparam logic [3:0] KEY_BYTES = 4'd4;
  localparam logic [3:0] HI_BYTES  = 4'd4;

endpackage

@@ src/wsfr_if.sv @@
// wsfr_in_if / wsfr_out_if: valid-ready channels of the frame receiver
// depends on wsfr_pkg for the payload types

interface wsfr_in_if;
  logic             valid;
  logic             ready;
  wsfr_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_out_if;
  logic             valid;
  logic             ready;
  wsfr_pkg::kind_t  result_kind;
  wsfr_pkg::byte_t  payload_byte;
  logic             last_of_frame;

  modport source (output valid, output result_kind, output payload_byte,
                  output last_of_frame, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input last_of_frame, output ready);
endinterface

@@ src/websocket_frame_receiver_unit.sv @@
// websocket_frame_receiver_unit: frame header parser and payload unmasker
// depends on wsfr_pkg and on the channel interfaces in wsfr_if.sv
//
// Usage:
//   rx carries one received byte per request. res carries at most one result
//   per byte: an unmasked payload byte (with last_of_frame on the final byte),
//   a close report, a bad opcode report, a length-too-large report or an
//   empty-message report. Valid headers give no result but for empty frames.
//   A result is registered and shows on res the cycle after its byte is taken.
//   Throughput: one byte per cycle while res does not stall, set by the single
//   parse step between the state registers and the result register.
//   rx.ready is high while the result register is empty or being taken, so a
//   stalled receiver on res holds the result and stops rx after one result.
//   Reset (rst, synchronous) clears the parser to await a first header byte
//   and empties the result register. After a close or an error every byte
//   is taken with no result until the next reset.

module websocket_frame_receiver_unit (
  input  logic              clk,
  input  logic              rst,
  wsfr_in_if.sink           rx,
  wsfr_out_if.source        res
);

  // state registers
  wsfr_pkg::phase_t    phase, phase_next;
  logic [3:0]          header_count, header_count_next;
  wsfr_pkg::len_mode_t length_mode, length_mode_next;
  logic [31:0]         payload_remaining, payload_remaining_next;
  logic [31:0]         mask_key, mask_key_next;
  logic [1:0]          key_position, key_position_next;

  // result register
  logic                out_valid;
  wsfr_pkg::kind_t     out_kind, out_kind_next;
  wsfr_pkg::byte_t     out_byte, out_byte_next;
  logic                out_last, out_last_next;
  logic                emit;

  logic                accept;
  logic [3:0]          len_bytes;
  logic [3:0]          count_inc;
  logic [31:0]         remaining_dec;
  wsfr_pkg::byte_t     key_byte;

  assign rx.ready = !out_valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  assign res.valid         = out_valid;
  assign res.result_kind   = out_kind;
  assign res.payload_byte  = out_byte;
  assign res.last_of_frame = out_last;

  // extended length bytes for the current form
  always_comb begin
    case (length_mode)
      wsfr_pkg::LEN_SHORT: len_bytes = 4'd0;
      wsfr_pkg::LEN_16:    len_bytes = 4'd2;
      default:             len_bytes = 4'd8;
    endcase
  end

  assign count_inc     = header_count + 4'd1;
  assign remaining_dec = payload_remaining - 32'd1;

  // key byte for this payload position, first key byte in the top bits
  always_comb begin
    case (key_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // one parse step per accepted byte
  always_comb begin
    phase_next             = phase;
    header_count_next      = header_count;
    length_mode_next       = length_mode;
    payload_remaining_next = payload_remaining;
    mask_key_next          = mask_key;
    key_position_next      = key_position;
    emit                   = 1'b0;
    out_kind_next          = wsfr_pkg::KIND_DATA;
    out_byte_next          = '0;
    out_last_next          = 1'b0;

    case (phase)
      wsfr_pkg::PH_FIRST: begin
        if (rx.rx_byte[3:0] == wsfr_pkg::OP_CLOSE) begin
          phase_next    = wsfr_pkg::PH_STOPPED;
          emit          = 1'b1;
          out_kind_next = wsfr_pkg::KIND_CLOSE;
        end else if (rx.rx_byte[3:0] != wsfr_pkg::OP_TEXT) begin
          phase_next    = wsfr_pkg::PH_STOPPED;
          emit          = 1'b1;
          out_kind_next = wsfr_pkg::KIND_BADOP;
        end else begin
          phase_next = wsfr_pkg::PH_SECOND;
        end
      end

      wsfr_pkg::PH_SECOND: begin
        header_count_next = '0;
        mask_key_next     = '0;
        phase_next        = wsfr_pkg::PH_EXT;
        if (rx.rx_byte[6:0] == wsfr_pkg::LEN7_16) begin
          length_mode_next       = wsfr_pkg::LEN_16;
          payload_remaining_next = '0;
        end else if (rx.rx_byte[6:0] == wsfr_pkg::LEN7_64) begin
          length_mode_next       = wsfr_pkg::LEN_64;
          payload_remaining_next = '0;
        end else begin
          length_mode_next       = wsfr_pkg::LEN_SHORT;
          payload_remaining_next = {25'd0, rx.rx_byte[6:0]};
        end
      end

      wsfr_pkg::PH_EXT: begin
        header_count_next = count_inc;
        if (header_count < len_bytes) begin
          // upper half of a 64-bit length must be zero
          if (length_mode == wsfr_pkg::LEN_64 && header_count < wsfr_pkg::HI_BYTES) begin
            if (rx.rx_byte != '0) begin
              phase_next    = wsfr_pkg::PH_STOPPED;
              emit          = 1'b1;
              out_kind_next = wsfr_pkg::KIND_TOOBIG;
            end
          end else begin
            payload_remaining_next = {payload_remaining[23:0], rx.rx_byte};
          end
        end else begin
          mask_key_next = {mask_key[23:0], rx.rx_byte};
        end
        // end of header: last key byte
        if (!emit && count_inc == len_bytes + wsfr_pkg::KEY_BYTES) begin
          key_position_next = '0;
          header_count_next = '0;
          if (payload_remaining_next == '0) begin
            phase_next    = wsfr_pkg::PH_FIRST;
            emit          = 1'b1;
            out_kind_next = wsfr_pkg::KIND_EMPTY;
          end else begin
            phase_next = wsfr_pkg::PH_PAYLOAD;
          end
        end
      end

      wsfr_pkg::PH_PAYLOAD: begin
        key_position_next      = key_position + 2'd1;
        payload_remaining_next = remaining_dec;
        emit                   = 1'b1;
        out_kind_next          = wsfr_pkg::KIND_DATA;
        out_byte_next          = rx.rx_byte ^ key_byte;
        out_last_next          = (remaining_dec == '0);
        if (remaining_dec == '0) begin
          phase_next = wsfr_pkg::PH_FIRST;
        end
      end

      default: begin
        // stopped: discard
      end
    endcase
  end

  // state update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsfr_pkg::PH_FIRST;
      header_count      <= '0;
      length_mode       <= wsfr_pkg::LEN_SHORT;
      payload_remaining <= '0;
      mask_key          <= '0;
      key_position      <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      header_count      <= header_count_next;
      length_mode       <= length_mode_next;
      payload_remaining <= payload_remaining_next;
      mask_key          <= mask_key_next;
      key_position      <= key_position_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind <= out_kind_next;
      out_byte <= out_byte_next;
      out_last <= out_last_next;
    end
  end

`ifndef ASSERT_OFF
  // a stopped parser stays stopped until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == wsfr_pkg::PH_STOPPED |=> phase == wsfr_pkg::PH_STOPPED)
    else $error("parser left stopped phase without reset");

  // payload phase always has bytes left to deliver
  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == wsfr_pkg::PH_PAYLOAD |-> payload_remaining != '0)
    else $error("payload phase with zero bytes remaining");

  // a payload byte accepted shows up as a data result next cycle
  a_payload_out: assert property (@(posedge clk) disable iff (rst)
    accept && phase == wsfr_pkg::PH_PAYLOAD |=>
      out_valid && out_kind == wsfr_pkg::KIND_DATA)
    else $error("payload byte did not produce a data result");

  // non-data results carry no byte and no end mark
  a_nondata_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != wsfr_pkg::KIND_DATA |-> out_byte == '0 && !out_last)
    else $error("non-data result with payload fields set");

  // header count never runs past the longest header
  a_hdr_bound: assert property (@(posedge clk) disable iff (rst)
    header_count <= 4'd11)
    else $error("header count out of range");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for websocket_frame_receiver_unit
// depends on wsfr_pkg, on the channel interfaces and on the receiver top level
// feeds text frames byte by byte and checks every unmasked byte and report

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AFTER  = 200;
  localparam int TAIL_BYTES  = 150;

  typedef struct packed {
    logic            hit;
    wsfr_pkg::kind_t kind;
    wsfr_pkg::byte_t data;
    logic            last;
  } frame_out_t;

  logic clk;
  logic rst;

  wsfr_in_if  rx_ch ();
  wsfr_out_if res_ch ();

  websocket_frame_receiver_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  // bytes still to send and results still to arrive
  wsfr_pkg::byte_t tx_bytes[$];
  frame_out_t      due_results[$];

  int  n_bytes;
  int  bytes_taken;
  int  results_got;
  int  errors;
  int  cycles;
  int  gap_left;
  int  idle_left;
  int  hold_left;
  logic hold_done;
  logic hold_on;
  logic noisy;
  logic calm;

  // predictor state
  wsfr_pkg::phase_t    fr_phase;
  logic [3:0]          hdr_idx;
  wsfr_pkg::len_mode_t len_form;
  logic [31:0]         bytes_left;
  logic [31:0]         key_word;
  logic [1:0]          key_idx;

  assign hold_on = (hold_left != 0);

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // parse one byte and return the result it causes, if any
  function automatic frame_out_t parse_rx_byte(wsfr_pkg::byte_t b);
    frame_out_t r;
    logic [3:0] ext_len;
    logic [3:0] idx;
    r = '0;
    case (fr_phase)
      wsfr_pkg::PH_FIRST: begin
        if (b[3:0] == wsfr_pkg::OP_CLOSE) begin
          fr_phase = wsfr_pkg::PH_STOPPED;
          r.hit = 1'b1;
          r.kind = wsfr_pkg::KIND_CLOSE;
        end else if (b[3:0] != wsfr_pkg::OP_TEXT) begin
          fr_phase = wsfr_pkg::PH_STOPPED;
          r.hit = 1'b1;
          r.kind = wsfr_pkg::KIND_BADOP;
        end else begin
          fr_phase = wsfr_pkg::PH_SECOND;
        end
      end
      wsfr_pkg::PH_SECOND: begin
        hdr_idx = '0;
        key_word = '0;
        bytes_left = '0;
        if (b[6:0] < wsfr_pkg::LEN7_16) begin
          len_form = wsfr_pkg::LEN_SHORT;
          bytes_left = {25'd0, b[6:0]};
        end else if (b[6:0] == wsfr_pkg::LEN7_16) begin
          len_form = wsfr_pkg::LEN_16;
        end else begin
          len_form = wsfr_pkg::LEN_64;
        end
        fr_phase = wsfr_pkg::PH_EXT;
      end
      wsfr_pkg::PH_EXT: begin
        ext_len = (len_form == wsfr_pkg::LEN_SHORT) ? 4'd0 :
                  (len_form == wsfr_pkg::LEN_16) ? 4'd2 : 4'd8;
        idx = hdr_idx;
        if (idx < ext_len) begin
          if (len_form == wsfr_pkg::LEN_64 && idx < wsfr_pkg::HI_BYTES) begin
            // upper half of a 64-bit length must be zero
            if (b != 8'd0) begin
              fr_phase = wsfr_pkg::PH_STOPPED;
              r.hit = 1'b1;
              r.kind = wsfr_pkg::KIND_TOOBIG;
              return r;
            end
          end else begin
            bytes_left = {bytes_left[23:0], b};
          end
        end else begin
          key_word = {key_word[23:0], b};
        end
        hdr_idx = idx + 4'd1;
        if (idx + 4'd1 == ext_len + wsfr_pkg::KEY_BYTES) begin
          key_idx = '0;
          hdr_idx = '0;
          if (bytes_left == 32'd0) begin
            fr_phase = wsfr_pkg::PH_FIRST;
            r.hit = 1'b1;
            r.kind = wsfr_pkg::KIND_EMPTY;
          end else begin
            fr_phase = wsfr_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfr_pkg::PH_PAYLOAD: begin
        r.hit = 1'b1;
        r.kind = wsfr_pkg::KIND_DATA;
        r.data = b ^ wsfr_pkg::byte_t'(key_word >> (8 * (3 - int'(key_idx))));
        key_idx = key_idx + 2'd1;
        bytes_left = bytes_left - 32'd1;
        r.last = (bytes_left == 32'd0);
        if (r.last) fr_phase = wsfr_pkg::PH_FIRST;
      end
      default: ;
    endcase
    return r;
  endfunction

  // queue one text frame with random flag bits and random payload
  task automatic add_frame(input wsfr_pkg::len_mode_t form, input logic [31:0] len,
                           input logic [31:0] key);
    wsfr_pkg::byte_t len7;
    len7 = (form == wsfr_pkg::LEN_SHORT) ? {1'b0, len[6:0]} :
           (form == wsfr_pkg::LEN_16) ? {1'b0, wsfr_pkg::LEN7_16} :
           {1'b0, wsfr_pkg::LEN7_64};
    tx_bytes.push_back({4'($urandom), wsfr_pkg::OP_TEXT});
    tx_bytes.push_back({1'($urandom), len7[6:0]});
    if (form == wsfr_pkg::LEN_16) begin
      tx_bytes.push_back(len[15:8]);
      tx_bytes.push_back(len[7:0]);
    end else if (form == wsfr_pkg::LEN_64) begin
      repeat (4) tx_bytes.push_back(8'd0);
      for (int i = 3; i >= 0; i--) tx_bytes.push_back(wsfr_pkg::byte_t'(len >> (8 * i)));
    end
    for (int i = 3; i >= 0; i--) tx_bytes.push_back(wsfr_pkg::byte_t'(key >> (8 * i)));
    for (int i = 0; i < int'(len); i++) tx_bytes.push_back(8'($urandom));
  endtask

  // stimulus and end of run
  initial begin
    logic [31:0] key;
    int sel;
    int pos;
    logic [3:0] op;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;

    // directed: empty frames in every length form, one-byte frame with all-ones key
    add_frame(wsfr_pkg::LEN_SHORT, 32'd0, $urandom);
    add_frame(wsfr_pkg::LEN_SHORT, 32'd1, 32'hFFFF_FFFF);
    add_frame(wsfr_pkg::LEN_16, 32'd0, 32'd0);
    add_frame(wsfr_pkg::LEN_64, 32'd0, $urandom);

    // longest short frame and a 16-bit length with a nonzero high byte
    add_frame(wsfr_pkg::LEN_SHORT, 32'd125, $urandom);
    add_frame(wsfr_pkg::LEN_16, 32'h0102, $urandom);

    // random well-formed frames, mostly short
    while (tx_bytes.size() < 1150) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: key = 32'd0;
        1: key = 32'hFFFF_FFFF;
        default: key = $urandom;
      endcase
      if (sel < 70)
        add_frame(wsfr_pkg::LEN_SHORT,
                  ($urandom_range(0, 19) == 0) ? $urandom_range(0, 125) :
                  $urandom_range(0, 12), key);
      else if (sel < 85)
        add_frame(wsfr_pkg::LEN_16, $urandom_range(0, 20), key);
      else
        add_frame(wsfr_pkg::LEN_64, $urandom_range(0, 20), key);
    end

    // one terminating event, then bytes that must be swallowed
    case ($urandom_range(0, 2))
      0: tx_bytes.push_back({4'($urandom), wsfr_pkg::OP_CLOSE});
      1: begin
        do op = 4'($urandom); while (op == wsfr_pkg::OP_TEXT || op == wsfr_pkg::OP_CLOSE);
        tx_bytes.push_back({4'($urandom), op});
      end
      default: begin
        pos = $urandom_range(0, 3);
        tx_bytes.push_back({4'($urandom), wsfr_pkg::OP_TEXT});
        tx_bytes.push_back({1'($urandom), wsfr_pkg::LEN7_64});
        repeat (pos) tx_bytes.push_back(8'd0);
        tx_bytes.push_back(wsfr_pkg::byte_t'($urandom_range(1, 255)));
      end
    endcase
    repeat (40) tx_bytes.push_back(8'($urandom));
    n_bytes = tx_bytes.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (bytes_taken < n_bytes);
    do @(posedge clk); while (due_results.size() != 0);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("PASS websocket_frame_receiver_unit");
    end else begin
      $display("FAIL websocket_frame_receiver_unit");
    end
    $finish;
  end

  // cycle count, idle mode and timeout
  initial begin
    cycles = 0;
    noisy = 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles[5:0] == 6'd0) noisy <= ($urandom_range(0, 3) != 0);
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL websocket_frame_receiver_unit");
      $finish;
    end
  end

  // byte driver with predictor update on each accepted request
  always @(posedge clk) begin : drv
    frame_out_t r;
    if (rst) begin
      rx_ch.valid <= 1'b0;
      gap_left <= 0;
      calm <= 1'b0;
      bytes_taken = 0;
      fr_phase = wsfr_pkg::PH_FIRST;
      hdr_idx = '0;
      len_form = wsfr_pkg::LEN_SHORT;
      bytes_left = '0;
      key_word = '0;
      key_idx = '0;
    end else begin
      calm <= (tx_bytes.size() < TAIL_BYTES);
      if (rx_ch.valid && rx_ch.ready) begin
        r = parse_rx_byte(rx_ch.rx_byte);
        if (r.hit) due_results.push_back(r);
        bytes_taken = bytes_taken + 1;
      end
      if (rx_ch.valid && !rx_ch.ready) begin
        // request still waiting, hold it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        rx_ch.valid <= 1'b0;
      end else if (tx_bytes.size() == 0) begin
        rx_ch.valid <= 1'b0;
      end else if (noisy && !calm && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 13);
        rx_ch.valid <= 1'b0;
      end else begin
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= tx_bytes.pop_front();
      end
    end
  end

  // long receiver hold-off once the stream is well under way
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_got >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // result monitor and receiver ready
  always @(posedge clk) begin : mon
    frame_out_t e;
    if (rst) begin
      res_ch.ready <= 1'b0;
      idle_left <= 0;
      results_got = 0;
      errors = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_got = results_got + 1;
        if (due_results.size() == 0) begin
          errors = errors + 1;
          $display("%0t: result expected none got kind %0d byte %02h last %0b", $time,
                   res_ch.result_kind, res_ch.payload_byte, res_ch.last_of_frame);
        end else begin
          e = due_results.pop_front();
          if (res_ch.result_kind !== e.kind) begin
            errors = errors + 1;
            $display("%0t: result_kind expected %0d got %0d", $time, e.kind,
                     res_ch.result_kind);
          end
          if (res_ch.payload_byte !== e.data) begin
            errors = errors + 1;
            $display("%0t: payload_byte expected %02h got %02h", $time, e.data,
                     res_ch.payload_byte);
          end
          if (res_ch.last_of_frame !== e.last) begin
            errors = errors + 1;
            $display("%0t: last_of_frame expected %0b got %0b", $time, e.last,
                     res_ch.last_of_frame);
          end
        end
      end
      if (hold_on) begin
        res_ch.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        res_ch.ready <= 1'b0;
      end else if (noisy && !calm && $urandom_range(0, 7) == 0) begin
        idle_left <= $urandom_range(0, 13);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

endmodule
